/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the playlist playback sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_TRACKS_DEF = 256;
  localparam int TIME_W         = 26;
  localparam int POS_W          = 9;
  localparam int CNT_W          = 9;
  localparam int THR_W          = 16;
  localparam int SECS_W         = 16;
  localparam int LFSR_W         = 16;
  localparam int DIVD_W         = 16;
  localparam int DIVS_W         = 9;
  localparam int CFG_W          = 16;
  localparam int MS_PER_S       = 1000;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [THR_W-1:0]  THR_RESET = 16'd3000;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  localparam logic [0:0] REG_TRACK_COUNT = 1'b0;
  localparam logic [0:0] REG_RESTART_THR = 1'b1;

  localparam logic [3:0] MODE_TICK   = 4'd0;
  localparam logic [3:0] MODE_PLAY   = 4'd1;
  localparam logic [3:0] MODE_PAUSE  = 4'd2;
  localparam logic [3:0] MODE_TOGGLE = 4'd3;
  localparam logic [3:0] MODE_STOP   = 4'd4;
  localparam logic [3:0] MODE_NEXT   = 4'd5;
  localparam logic [3:0] MODE_PREV   = 4'd6;
  localparam logic [3:0] MODE_SEEK   = 4'd7;
  localparam logic [3:0] MODE_START  = 4'd8;
  localparam logic [3:0] MODE_ORDER  = 4'd9;
  localparam logic [3:0] MODE_LOAD   = 4'd10;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PLAYING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;

  localparam logic [1:0] ORD_LIST   = 2'd0;
  localparam logic [1:0] ORD_SINGLE = 2'd1;
  localparam logic [1:0] ORD_SHUF   = 2'd2;
  localparam logic [1:0] ORD_SEQ    = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] elapsed_ms;
    logic [25:0] target_ms;
    logic [7:0]  item_index;
    logic [15:0] entry_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]  playback_state;
    logic [7:0]  current_index;
    logic [25:0] position_ms;
    logic [1:0]  order_now;
    logic        track_started;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_EXEC, OP_NEXT, OP_DIV2START, OP_SETPOS,
    OP_READ, OP_BEGIN, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    R_DONE, R_NEXT, R_BEGIN, R_SHUF, R_MODN
  } route_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_NEXT, S_DIV1, S_DIV2, S_READ, S_BEGIN, S_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    route_t route;
    logic   div_done;
    logic   out_busy;
  } sts_t;

endpackage

/* rtl/pps_ram.sv */
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pps_div.sv */
// ----------------------------------------------------------------------------
// pps_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pps_div
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVS_W-1:0] rem
);

  localparam int STEP_W = $clog2(DIVD_W);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DIVD_W-1:0] dq;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dq[DIVD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = DIVS_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dq  <= {dq[DIVD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

/* rtl/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for one request: decode, next-track resolution, table read, reply.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC, S_NEXT: begin
        case (sts.route)
          R_NEXT:  state_next = S_NEXT;
          R_BEGIN: state_next = S_READ;
          R_SHUF:  state_next = S_DIV1;
          R_MODN:  state_next = S_DIV2;
          default: state_next = S_OUT;
        endcase
      end
      S_DIV1: begin
        if (sts.div_done) state_next = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) state_next = S_READ;
      end
      S_READ:  state_next = S_BEGIN;
      S_BEGIN: state_next = S_OUT;
      S_OUT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_CAPTURE;
      S_EXEC:  cmd.op = OP_EXEC;
      S_NEXT:  cmd.op = OP_NEXT;
      S_DIV1:  if (sts.div_done) cmd.op = OP_DIV2START;
      S_DIV2:  if (sts.div_done) cmd.op = OP_SETPOS;
      S_READ:  cmd.op = OP_READ;
      S_BEGIN: cmd.op = OP_BEGIN;
      S_OUT:   if (!sts.out_busy) cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/pps_dp.sv */
// ----------------------------------------------------------------------------
// pps_dp
// Player state, config registers, duration table, shuffle LFSR, output stage.
// ----------------------------------------------------------------------------
module pps_dp
  import pps_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int ADDR_W = $clog2(MAX_TRACKS);

  logic [CNT_W-1:0]  track_count;
  logic [THR_W-1:0]  thr;
  req_t              req;
  logic [1:0]        run_state;
  logic [1:0]        play_order;
  logic [POS_W-1:0]  pos;
  logic [TIME_W-1:0] play_time;
  logic [TIME_W-1:0] track_len;
  logic              has_track;
  logic              loaded;
  logic [LFSR_W-1:0] lfsr;
  logic              started;

  logic [CNT_W-1:0]  n;
  logic [TIME_W:0]   tick_sum;
  logic [TIME_W-1:0] tick_time;
  logic [LFSR_W-1:0] lfsr_next;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  prev_pos;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVS_W-1:0] div_rem;
  logic              ram_we;
  logic [SECS_W-1:0] ram_rdata;
  logic              pos_ok;
  route_t            route;

  assign n = (32'(track_count) < MAX_TRACKS) ? track_count : CNT_W'(MAX_TRACKS);

  assign tick_sum  = {1'b0, play_time} + (TIME_W+1)'(req.elapsed_ms);
  assign tick_time = tick_sum[TIME_W] ? TIME_MAX : tick_sum[TIME_W-1:0];
  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign start_pos = ({1'b0, req.item_index} < (n - 1'b1)) ? {1'b0, req.item_index}
                                                           : n - 1'b1;
  assign prev_pos  = (pos == '0) ? n - 1'b1 : pos - 1'b1;
  assign pos_ok    = 32'(pos) < MAX_TRACKS;

  always_comb begin
    route = R_DONE;
    case (cmd.op)
      OP_EXEC: begin
        case (req.mode)
          MODE_TICK: begin
            if (run_state == ST_PLAYING && track_len != '0 && tick_time >= track_len)
              route = R_NEXT;
          end
          MODE_NEXT: route = R_NEXT;
          MODE_PREV: begin
            if (loaded && n != '0 && !(play_time > TIME_W'(thr))) route = R_BEGIN;
          end
          MODE_START: begin
            if (n != '0) route = R_BEGIN;
          end
          default: route = R_DONE;
        endcase
      end
      OP_NEXT: begin
        if (loaded && n != '0) begin
          case (play_order)
            ORD_SINGLE: route = R_DONE;
            ORD_SHUF:   route = (n > CNT_W'(1)) ? R_SHUF : R_BEGIN;
            ORD_SEQ:    route = (({1'b0, pos} + 1'b1) < {1'b0, n}) ? R_BEGIN : R_DONE;
            default:    route = R_MODN;
          endcase
        end
      end
      default: route = R_DONE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVD_W'(pos) + DIVD_W'(1);
    div_divisor  = n;
    if (cmd.op == OP_NEXT && route == R_SHUF) begin
      div_start    = 1'b1;
      div_dividend = lfsr_next;
      div_divisor  = n - 1'b1;
    end else if (cmd.op == OP_NEXT && route == R_MODN) begin
      div_start = 1'b1;
    end else if (cmd.op == OP_DIV2START) begin
      div_start    = 1'b1;
      div_dividend = DIVD_W'(pos) + DIVD_W'(1) + DIVD_W'(div_rem);
    end
  end

  assign sts.route    = route;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid && !out_ready;

  assign ram_we = (cmd.op == OP_EXEC) && (req.mode == MODE_LOAD) &&
                  (32'(req.item_index) < MAX_TRACKS);

  pps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  pps_ram #(
    .WIDTH (SECS_W),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(req.item_index)),
    .wdata (req.entry_seconds),
    .re    (cmd.op == OP_READ),
    .raddr (ADDR_W'(pos)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count <= '0;
      thr         <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACK_COUNT: track_count <= cfg_data[CNT_W-1:0];
        REG_RESTART_THR: thr         <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) req <= in_data;
    if (cmd.op == OP_OUT) begin
      out_data.playback_state <= run_state;
      out_data.current_index  <= pos[7:0];
      out_data.position_ms    <= play_time;
      out_data.order_now      <= play_order;
      out_data.track_started  <= started;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state  <= ST_IDLE;
      play_order <= ORD_LIST;
      pos        <= '0;
      play_time  <= '0;
      track_len  <= '0;
      has_track  <= 1'b0;
      loaded     <= 1'b0;
      lfsr       <= LFSR_SEED;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CAPTURE: started <= 1'b0;
        OP_EXEC: begin
          case (req.mode)
            MODE_TICK: begin
              if (run_state == ST_PLAYING) play_time <= tick_time;
            end
            MODE_PLAY: begin
              if (has_track) run_state <= ST_PLAYING;
            end
            MODE_PAUSE: begin
              if (run_state == ST_PLAYING) run_state <= ST_PAUSED;
            end
            MODE_TOGGLE: begin
              if (run_state == ST_PLAYING) run_state <= ST_PAUSED;
              else if (has_track) run_state <= ST_PLAYING;
            end
            MODE_STOP: begin
              run_state <= ST_IDLE;
              play_time <= '0;
            end
            MODE_PREV: begin
              if (loaded && n != '0) begin
                if (play_time > TIME_W'(thr)) play_time <= '0;
                else pos <= prev_pos;
              end
            end
            MODE_SEEK: begin
              play_time <= (req.target_ms < track_len) ? req.target_ms : track_len;
            end
            MODE_START: begin
              loaded <= 1'b1;
              if (n == '0) begin
                run_state <= ST_IDLE;
                play_time <= '0;
              end else begin
                pos <= start_pos;
              end
            end
            MODE_ORDER: play_order <= play_order + 1'b1;
            default: ;
          endcase
        end
        OP_NEXT: begin
          if (loaded && n != '0) begin
            case (play_order)
              ORD_SINGLE: begin
                play_time <= '0;
                if (has_track) begin
                  run_state <= ST_PLAYING;
                  started   <= 1'b1;
                end
              end
              ORD_SHUF: begin
                if (route == R_SHUF) lfsr <= lfsr_next;
              end
              ORD_SEQ: begin
                if (route == R_BEGIN) begin
                  pos <= pos + 1'b1;
                end else begin
                  run_state <= ST_IDLE;
                  play_time <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        OP_SETPOS: pos <= div_rem;
        OP_BEGIN: begin
          track_len <= pos_ok ? TIME_W'(TIME_W'(ram_rdata) * TIME_W'(MS_PER_S)) : '0;
          play_time <= '0;
          run_state <= ST_PLAYING;
          has_track <= 1'b1;
          started   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_started_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.track_started || out_data.playback_state == ST_PLAYING))
    else $error("track start reported while not playing");

  a_begin_effect: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_BEGIN |=> (started && run_state == ST_PLAYING && has_track))
    else $error("track begin did not take effect");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> div_divisor != '0)
    else $error("remainder unit started with zero divisor");

  a_setpos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SETPOS |=> pos < n)
    else $error("wrapped position out of range");

endmodule

/* rtl/playlist_playback_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// playlist_playback_sequencer_unit
// Playlist playback sequencer: transport, navigation, play orders, durations.
// ----------------------------------------------------------------------------
// Shuffle picks the next track with two remainder passes in the shared divider.
// Throughput: one request at a time; next request taken once the reply is
// registered. Reply waits in an output register.
// Reset: synchronous; clears all control state; duration table is not cleared.
// ----------------------------------------------------------------------------
module playlist_playback_sequencer_unit
  import pps_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
